// ===== design/exact_sign_flip_test_top_defines.svh =====
// Assertion macros for the exact sign-flip test block.
// Included by the top level; no other dependencies.
`ifndef EXACT_SIGN_FLIP_TEST_TOP_DEFINES_SVH
`define EXACT_SIGN_FLIP_TEST_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ESFT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ESFT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ESFT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ESFT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== design/esft_pkg.sv =====
// Shared constants for the exact sign-flip test block.
// No dependencies.
`timescale 1ns / 1ps

package esft_pkg;

    localparam int COUNT_W = 21;
    localparam int ITEMS_W = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

endpackage

// ===== design/esft_store.sv =====
// Generic RAM holding the differences of one set.
// One write port, one read port with registered data; no dependencies.
`timescale 1ns / 1ps

module esft_store #(
    parameter int DEPTH = 20,
    parameter int WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic signed [WIDTH-1:0]               wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic signed [WIDTH-1:0]               rd_data
);

    logic signed [WIDTH-1:0] mem_reg [DEPTH];
    logic signed [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/esft_core.sv =====
// Enumeration sequencer: walks all sign assignments in Gray-code order with
// one shared add/subtract unit and counts the extreme ones.
// Depends on esft_pkg; fetches from the difference store in the cycle before use.
`timescale 1ns / 1ps

module esft_core
    import esft_pkg::*;
#(
    parameter int MAX_ITEMS  = 20,
    parameter int DIFF_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start_valid,
    input  logic [$clog2(MAX_ITEMS+1)-1:0]        start_n,
    input  logic signed [DIFF_WIDTH+$clog2(MAX_ITEMS+1):0] start_obs,
    output logic [((MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1)-1:0] rd_addr,
    input  logic signed [DIFF_WIDTH-1:0]          rd_data,
    input  logic                                  out_free,
    output logic                                  done_valid,
    output logic [COUNT_W-1:0]                    done_count
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W = DIFF_WIDTH + CNT_W + 1;
    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int K_W   = MAX_ITEMS + 1;
    localparam int CW    = (K_W > COUNT_W) ? K_W : COUNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_RUN,
        ST_HOLD
    } state_t;

    state_t                    state_reg;
    logic [CNT_W-1:0]          n_reg;
    logic signed [SUM_W-1:0]   obs_reg;
    logic signed [SUM_W-1:0]   run_reg;
    logic signed [SUM_W-1:0]   pos_reg;
    logic signed [SUM_W-1:0]   neg_reg;
    logic [K_W-1:0]            k_reg;
    logic [K_W-1:0]            match_reg;

    logic signed [SUM_W-1:0]   neg_obs;
    logic signed [SUM_W-1:0]   step;
    logic signed [SUM_W-1:0]   run_next;
    logic [K_W-1:0]            match_next;
    logic [K_W-1:0]            low_one;
    logic [K_W-1:0]            k_ahead;
    logic [K_W-1:0]            low_ahead;
    logic [K_W-1:0]            fin_count;
    logic [CW-1:0]             count_ext;
    logic [IDX_W-1:0]          b_idx;
    logic                      hit;
    logic                      fin;
    logic                      flip_up;

    always_comb begin
        neg_obs    = -obs_reg;
        hit        = (run_reg >= pos_reg) || (run_reg <= neg_reg);
        match_next = match_reg + K_W'(hit);
        fin        = k_reg[n_reg];

        // isolate the lowest set bit of k: that is the sign that flips
        low_one = k_reg & (~k_reg + K_W'(1));

        // fetch the difference for the next flip in the cycle before its use
        k_ahead   = (state_reg == ST_RUN) ? (k_reg + K_W'(1)) : K_W'(1);
        low_ahead = k_ahead & (~k_ahead + K_W'(1));
        b_idx     = '0;
        for (int i = 0; i < MAX_ITEMS; i++) begin
            if (low_ahead[i]) begin
                b_idx = b_idx | IDX_W'(i);
            end
        end
        // the Gray bit goes to one when the next bit of k is clear
        flip_up  = ((k_reg & (low_one << 1)) == '0);
        step     = SUM_W'(rd_data) <<< 1;
        run_next = flip_up ? (run_reg + step) : (run_reg - step);

        fin_count  = (state_reg == ST_HOLD) ? match_reg : match_next;
        count_ext  = CW'(fin_count);
        done_count = (count_ext > CW'(COUNT_MAX)) ? COUNT_MAX : count_ext[COUNT_W-1:0];
        done_valid = out_free && ((state_reg == ST_HOLD) || ((state_reg == ST_RUN) && fin));
    end

    assign rd_addr = b_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (start_valid) begin
                        n_reg     <= start_n;
                        obs_reg   <= start_obs;
                        state_reg <= ST_INIT;
                    end
                end
                ST_INIT: begin
                    // start with every sign negative
                    run_reg   <= neg_obs;
                    pos_reg   <= obs_reg[SUM_W-1] ? neg_obs : obs_reg;
                    neg_reg   <= obs_reg[SUM_W-1] ? obs_reg : neg_obs;
                    k_reg     <= K_W'(1);
                    match_reg <= '0;
                    state_reg <= ST_RUN;
                end
                ST_RUN: begin
                    match_reg <= match_next;
                    if (fin) begin
                        state_reg <= out_free ? ST_IDLE : ST_HOLD;
                    end else begin
                        run_reg <= run_next;
                        k_reg   <= k_reg + K_W'(1);
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/exact_sign_flip_test_top.sv =====
// Exact sign-flip permutation test on Q7.24 paired differences.
//
// Input channel s_*: one signed difference per transfer, s_last marks the final
// one of a set. Up to MAX_ITEMS differences are stored, one per cycle while
// s_ready is high; later ones are dropped and reported through m_overflow.
// After the last transfer the enumerator walks all 2^n sign assignments in
// Gray-code order, one add or subtract per cycle on a single shared adder.
// s_ready is low during that walk; it returns high once the result is in the
// output register, so the next set loads while the result waits.
// Output channel m_*: one transfer per set with the extreme count (saturating at
// 2^21 - 1), n, and the overflow flag. If the receiver stalls, the result holds;
// a further finished walk waits in the enumerator until the register frees.
// Reset (aresetn low, synchronous) clears the load count, the running sum, the
// overflow flag and all valid state; stored differences are not cleared.
// Depends on esft_pkg, esft_store, esft_core and the defines header.
`timescale 1ns / 1ps
`include "exact_sign_flip_test_top_defines.svh"

module exact_sign_flip_test_top
    import esft_pkg::*;
#(
    parameter int MAX_ITEMS  = 20,
    parameter int DIFF_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [DIFF_WIDTH-1:0] s_diff_value,
    input  logic                         s_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [COUNT_W-1:0]           m_extreme_count,
    output logic [ITEMS_W-1:0]           m_items_used,
    output logic                         m_overflow
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W = DIFF_WIDTH + CNT_W + 1;
    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    logic                      busy_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [SUM_W-1:0]   obs_reg;
    logic                      drop_reg;
    logic [CNT_W-1:0]          run_n_reg;
    logic                      run_drop_reg;
    logic                      m_valid_reg;
    logic [COUNT_W-1:0]        m_count_reg;
    logic [ITEMS_W-1:0]        m_items_reg;
    logic                      m_ovf_reg;

    logic                      accept;
    logic                      store_ok;
    logic                      start_valid;
    logic [CNT_W-1:0]          cnt_next;
    logic signed [SUM_W-1:0]   obs_next;
    logic                      out_free;
    logic [IDX_W-1:0]          rd_addr;
    logic signed [DIFF_WIDTH-1:0] rd_data;
    logic                      done_valid;
    logic [COUNT_W-1:0]        done_count;

    always_comb begin
        accept      = s_valid && s_ready;
        store_ok    = (cnt_reg < CNT_W'(MAX_ITEMS));
        start_valid = accept && s_last;
        cnt_next    = store_ok ? (cnt_reg + CNT_W'(1)) : cnt_reg;
        obs_next    = store_ok ? (obs_reg + SUM_W'(s_diff_value)) : obs_reg;
        out_free    = !m_valid_reg || m_ready;
    end

    assign s_ready         = !busy_reg;
    assign m_valid         = m_valid_reg;
    assign m_extreme_count = m_count_reg;
    assign m_items_used    = m_items_reg;
    assign m_overflow      = m_ovf_reg;

    esft_store #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (DIFF_WIDTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (accept && store_ok),
        .wr_addr (cnt_reg[IDX_W-1:0]),
        .wr_data (s_diff_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    esft_core #(
        .MAX_ITEMS  (MAX_ITEMS),
        .DIFF_WIDTH (DIFF_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start_valid (start_valid),
        .start_n     (cnt_next),
        .start_obs   (obs_next),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .out_free    (out_free),
        .done_valid  (done_valid),
        .done_count  (done_count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            obs_reg     <= '0;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (s_last) begin
                    // hand the set to the enumerator and start a fresh one
                    run_n_reg    <= cnt_next;
                    run_drop_reg <= drop_reg || !store_ok;
                    cnt_reg      <= '0;
                    obs_reg      <= '0;
                    drop_reg     <= 1'b0;
                    busy_reg     <= 1'b1;
                end else begin
                    cnt_reg  <= cnt_next;
                    obs_reg  <= obs_next;
                    drop_reg <= drop_reg || !store_ok;
                end
            end

            if (done_valid) begin
                busy_reg    <= 1'b0;
                m_valid_reg <= 1'b1;
                m_count_reg <= done_count;
                m_items_reg <= ITEMS_W'(run_n_reg);
                m_ovf_reg   <= run_drop_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    `ESFT_ASSERT_NXT(a_busy_after_last, aclk, aresetn, s_valid && s_ready && s_last,
        !s_ready, "input still ready after the last transfer of a set")
    `ESFT_ASSERT_IMP(a_done_while_busy, aclk, aresetn, done_valid,
        busy_reg, "enumeration finished with no set loaded")
    `ESFT_ASSERT_IMP(a_overflow_full, aclk, aresetn, m_valid && m_overflow,
        m_items_used == ITEMS_W'(MAX_ITEMS), "overflow reported with the store not full")
    `ESFT_ASSERT_IMP(a_count_nonzero, aclk, aresetn, m_valid,
        m_extreme_count != '0, "observed assignment missing from the extreme count")

endmodule
